// ===== rtl/kme_pkg.sv =====
// Shared types and constants for the keyboard matrix emulator.
`default_nettype none

package kme_pkg;

  localparam int unsigned ROW_LINES_W = 7;
  localparam int unsigned PIN_W       = 8;
  localparam int unsigned HOLD_W      = 16;
  localparam int unsigned TOUCH_W     = 12;
  localparam int unsigned TOUCH_SLOTS = 9;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned CELL_W      = 3;

  localparam logic [HOLD_W-1:0]  MIN_HOLD_RESET = 16'd1000;
  localparam logic [TOUCH_W-1:0] TOUCH_VALID    = 12'h010;
  localparam logic [PIN_W-1:0]   LEVEL_RESET    = 8'hFF;

  typedef enum logic [2:0] {
    OP_KEY   = 3'd0,
    OP_POWER = 3'd1,
    OP_TOUCH = 3'd2,
    OP_TICK  = 3'd3,
    OP_PINS  = 3'd4
  } op_t;

  typedef logic [2:0] pin_idx_t;

  localparam pin_idx_t COL_PIN [8] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd6, 3'd7, 3'd5
  };

  localparam logic [TOUCH_W-1:0] TOUCH_BIT [TOUCH_SLOTS] = '{
    12'h002, 12'h004, 12'h008, 12'h020, 12'h040,
    12'h100, 12'h200, 12'h400, 12'h800
  };

endpackage

`default_nettype wire

// ===== rtl/kme_ifs.sv =====
// Handshake channel interfaces for key events and line status items.
`default_nettype none

interface kme_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [2:0] key_col;
  logic [2:0] key_row;
  logic [3:0] touch_slot;
  logic       key_down;
  logic [7:0] pin_output_enable;
  logic [7:0] pin_output_level;

  modport source (
    output valid, operation, key_col, key_row, touch_slot, key_down,
           pin_output_enable, pin_output_level,
    input  ready
  );
  modport sink (
    input  valid, operation, key_col, key_row, touch_slot, key_down,
           pin_output_enable, pin_output_level,
    output ready
  );
endinterface

interface kme_status_if;
  logic        valid;
  logic        ready;
  logic [6:0]  row_lines;
  logic        power_sense;
  logic        attention;
  logic [11:0] touch_report;

  modport source (
    output valid, row_lines, power_sense, attention, touch_report,
    input  ready
  );
  modport sink (
    input  valid, row_lines, power_sense, attention, touch_report,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/keyboard_matrix_emulator.sv =====
// Keyboard matrix emulator top level: key state, hold countdown and status output.
//
// Usage:
//   events carries one key, power, touch, tick or column-pin item per handshake;
//   status returns one item per accepted event: row lines (active low), power
//   sense, attention level and the touchkey report, all as they stand after
//   that event.
//   cfg_wr_en/cfg_wr_data write the minimum hold tick count (reset 1000).
// The status item for an event is registered and valid in the cycle after acceptance.
// Throughput: one event per cycle; the whole state update is one register
//   stage, so events.ready stays high while the status register is empty or
//   is being taken in the same cycle.
// Stall: while status.valid is high and status.ready low, the status item
//   holds and events.ready is low; no event is lost or taken.
// Reset (rst, synchronous): clears both key maps, the countdown, power,
//   attention and touch bits, column enables to 0 and column levels to all
//   ones; the hold count returns to 1000 and no status item is pending.
`default_nettype none

module keyboard_matrix_emulator #(
  parameter int unsigned NUM_COLS = 7,
  parameter int unsigned NUM_ROWS = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [kme_pkg::HOLD_W-1:0]    cfg_wr_data,
  kme_event_if.sink                          events,
  kme_status_if.source                       status
);

  localparam int unsigned COL_CMP_W = kme_pkg::CELL_W + 1;

  logic [kme_pkg::HOLD_W-1:0]            min_hold;
  logic [NUM_COLS-1:0][NUM_ROWS-1:0]     wanted;
  logic [NUM_COLS-1:0][NUM_ROWS-1:0]     held;
  logic [kme_pkg::HOLD_W-1:0]            hold_remaining;
  logic                                  power_held;
  logic                                  attention_level;
  logic [kme_pkg::TOUCH_W-1:0]           touch_pressed;
  logic [kme_pkg::PIN_W-1:0]             column_enable;
  logic [kme_pkg::PIN_W-1:0]             column_level;
  logic                                  out_valid;
  logic [kme_pkg::ROW_LINES_W-1:0]       out_rows;
  logic                                  out_power;
  logic                                  out_attention;
  logic [kme_pkg::TOUCH_W-1:0]           out_touch;

  logic [NUM_COLS-1:0][NUM_ROWS-1:0]     wanted_next;
  logic [NUM_COLS-1:0][NUM_ROWS-1:0]     held_next;
  logic [kme_pkg::HOLD_W-1:0]            hold_remaining_next;
  logic                                  power_held_next;
  logic                                  attention_level_next;
  logic [kme_pkg::TOUCH_W-1:0]           touch_pressed_next;
  logic [kme_pkg::PIN_W-1:0]             column_enable_next;
  logic [kme_pkg::PIN_W-1:0]             column_level_next;
  logic [kme_pkg::ROW_LINES_W-1:0]       rows_next;

  logic                                  accept;
  logic                                  cell_hit;
  logic                                  do_drop;
  logic [NUM_COLS-1:0]                   sel_col;
  logic [NUM_ROWS-1:0]                   sel_row;
  logic [NUM_COLS-1:0][NUM_ROWS-1:0]     gone;

  assign events.ready = !out_valid || status.ready;
  assign accept       = events.valid && events.ready;

  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      sel_col[c] = (events.key_col == kme_pkg::CELL_W'(c));
    end
    for (int r = 0; r < NUM_ROWS; r++) begin
      sel_row[r] = (events.key_row == kme_pkg::CELL_W'(r));
    end
    cell_hit = ({1'b0, events.key_col} < COL_CMP_W'(NUM_COLS)) &&
               ({1'b0, events.key_row} < COL_CMP_W'(NUM_ROWS));

    wanted_next          = wanted;
    held_next            = held;
    hold_remaining_next  = hold_remaining;
    power_held_next      = power_held;
    attention_level_next = attention_level;
    touch_pressed_next   = touch_pressed;
    column_enable_next   = column_enable;
    column_level_next    = column_level;
    do_drop              = 1'b0;

    case (events.operation)
      kme_pkg::OP_KEY: begin
        if (cell_hit) begin
          for (int c = 0; c < NUM_COLS; c++) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
              if (sel_col[c] && sel_row[r]) begin
                wanted_next[c][r] = events.key_down;
                if (events.key_down) begin
                  held_next[c][r] = 1'b1;
                end
              end
            end
          end
          if (events.key_down) begin
            attention_level_next = 1'b1;
            hold_remaining_next  = min_hold;
          end else begin
            do_drop = (hold_remaining == '0);
          end
        end
      end
      kme_pkg::OP_POWER: begin
        power_held_next      = events.key_down;
        attention_level_next = events.key_down;
      end
      kme_pkg::OP_TOUCH: begin
        if ({1'b0, events.touch_slot} < 5'(kme_pkg::TOUCH_SLOTS)) begin
          if (events.key_down) begin
            touch_pressed_next = touch_pressed | kme_pkg::TOUCH_BIT[events.touch_slot];
          end else begin
            touch_pressed_next = touch_pressed & ~kme_pkg::TOUCH_BIT[events.touch_slot];
          end
        end
      end
      kme_pkg::OP_TICK: begin
        if (hold_remaining != '0) begin
          hold_remaining_next = hold_remaining - kme_pkg::HOLD_W'(1);
          do_drop             = (hold_remaining == kme_pkg::HOLD_W'(1));
        end
      end
      kme_pkg::OP_PINS: begin
        column_enable_next = events.pin_output_enable;
        column_level_next  = events.pin_output_level;
      end
      default: begin
      end
    endcase

    gone = held_next & ~wanted_next;
    if (do_drop) begin
      held_next = held_next & wanted_next;
      if (gone != '0) begin
        attention_level_next = 1'b0;
      end
    end
  end

  kme_row_view #(
    .NUM_COLS (NUM_COLS),
    .NUM_ROWS (NUM_ROWS)
  ) u_row_view (
    .held       (held_next),
    .pin_enable (column_enable_next),
    .pin_level  (column_level_next),
    .row_lines  (rows_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_hold        <= kme_pkg::MIN_HOLD_RESET;
      wanted          <= '0;
      held            <= '0;
      hold_remaining  <= '0;
      power_held      <= 1'b0;
      attention_level <= 1'b0;
      touch_pressed   <= '0;
      column_enable   <= '0;
      column_level    <= kme_pkg::LEVEL_RESET;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        min_hold <= cfg_wr_data;
      end
      if (accept) begin
        wanted          <= wanted_next;
        held            <= held_next;
        hold_remaining  <= hold_remaining_next;
        power_held      <= power_held_next;
        attention_level <= attention_level_next;
        touch_pressed   <= touch_pressed_next;
        column_enable   <= column_enable_next;
        column_level    <= column_level_next;
        out_valid       <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rows      <= rows_next;
      out_power     <= power_held_next;
      out_attention <= attention_level_next;
      out_touch     <= kme_pkg::TOUCH_VALID | touch_pressed_next;
    end
  end

  assign status.valid        = out_valid;
  assign status.row_lines    = out_rows;
  assign status.power_sense  = out_power;
  assign status.attention    = out_attention;
  assign status.touch_report = out_touch;

`ifndef SYNTH
  a_attention_rise: assert property (@(posedge clk) disable iff (rst)
    (attention_level && !$past(attention_level) && !$past(rst)) |->
      $past(accept && (events.operation == kme_pkg::OP_KEY ||
                       events.operation == kme_pkg::OP_POWER)))
    else $error("attention rose without a key or power press");

  a_held_covered: assert property (@(posedge clk) disable iff (rst)
    ((wanted & ~held) == '0))
    else $error("wanted key not shown as held");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no status item");

  a_attention_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && $past(accept)) |-> (out_attention == attention_level))
    else $error("status attention differs from attention state");
`endif

endmodule

`default_nettype wire

// ===== rtl/kme_row_view.sv =====
// Row sense view: held keys in columns driven low pull active-low row lines.
`default_nettype none

module kme_row_view #(
  parameter int unsigned NUM_COLS = 7,
  parameter int unsigned NUM_ROWS = 7
) (
  input  wire logic [NUM_COLS-1:0][NUM_ROWS-1:0]   held,
  input  wire logic [kme_pkg::PIN_W-1:0]           pin_enable,
  input  wire logic [kme_pkg::PIN_W-1:0]           pin_level,
  output logic      [kme_pkg::ROW_LINES_W-1:0]     row_lines
);

  logic [NUM_ROWS-1:0] pulled;

  always_comb begin
    pulled = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      if (pin_enable[kme_pkg::COL_PIN[c]] && !pin_level[kme_pkg::COL_PIN[c]]) begin
        pulled = pulled | held[c];
      end
    end
  end

  for (genvar r = 0; r < kme_pkg::ROW_LINES_W; r++) begin : g_row
    if (r < NUM_ROWS) begin : g_live
      assign row_lines[r] = ~pulled[r];
    end else begin : g_idle
      assign row_lines[r] = 1'b1;
    end
  end

endmodule

`default_nettype wire
